>>> rtl/sobel_et_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Field widths, register indexes, reset values and shared types for the
// streaming 3x3 Sobel edge detector.
// ----------------------------------------------------------------------------
package sobel_et_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COORD_W     = 11;
    localparam int MAG_W       = 11;
    localparam int THR_W       = 11;
    localparam int SIZE_W      = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int MAX_WIDTH_DEFAULT  = 2048;
    localparam int MAX_HEIGHT_DEFAULT = 2048;
    localparam int MIN_SIZE           = 3;
    localparam int MAG_MAX            = 2040;

    localparam int THR_RESET    = 100;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef logic [PIXEL_W-1:0]     pixel_t;
    typedef logic [COORD_W-1:0]     coord_t;
    typedef logic [MAG_W-1:0]       mag_t;
    typedef logic [THR_W-1:0]       thr_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_EDGE_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_IMAGE_WIDTH    = 2'd1;
    localparam cfg_index_t CFG_IMAGE_HEIGHT   = 2'd2;

endpackage

>>> rtl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold
// Streaming 3x3 Sobel edge detector with two line stores and a magnitude
// threshold.
// ----------------------------------------------------------------------------
//
// Grayscale pixels enter in raster order on the pixel channel (pixel_valid,
// pixel_stall, gray_pixel); one transfer moves one pixel. Once the window is
// complete (input at column 2 or more and row 2 or more) the block delivers
// one result on the result channel for the window centre, one row and one
// column behind the input: its coordinates, the L1 gradient |Gx|+|Gy| and the
// edge flag. Border pixels give no result.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and is to be written only while the block is idle.
// Throughput is one pixel per cycle while the receiver does not stall. A
// result appears after the transfer of the pixel that completes its window:
// stage 1 does the line store read, stage 2 the window update, then the
// gradient goes into the result register.
// Reset clears the counters, the window and the pipeline valid flags and
// loads the register reset values; the line stores are not cleared, so no
// clearing pass is needed. While the receiver stalls, the result holds and
// the two inner stages still fill, so pixel_stall only rises once all three
// stages hold an item.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = sobel_et_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = sobel_et_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     pixel_valid,
    output logic                     pixel_stall,
    input  sobel_et_pkg::pixel_t     gray_pixel,

    output logic                     result_valid,
    input  logic                     result_stall,
    output sobel_et_pkg::coord_t     center_col,
    output sobel_et_pkg::coord_t     center_row,
    output sobel_et_pkg::mag_t       grad_magnitude,
    output logic                     is_edge,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  sobel_et_pkg::cfg_index_t cfg_index,
    input  sobel_et_pkg::cfg_data_t  cfg_data
);

    // Address bits of a line store and of the row counter. The image sizes
    // are kept one bit wider so that they can hold the maxima themselves.
    localparam int AW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int WIDTH_RESET_C  = (sobel_et_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                    MAX_WIDTH : sobel_et_pkg::WIDTH_RESET;
    localparam int HEIGHT_RESET_C = (sobel_et_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                    MAX_HEIGHT : sobel_et_pkg::HEIGHT_RESET;

    typedef logic [AW-1:0] col_t;
    typedef logic [AW:0]   width_t;
    typedef logic [RW-1:0] row_t;
    typedef logic [RW:0]   height_t;
    typedef logic [9:0]    half_t;

    // Window: [row 0 top .. 2 bottom][column 0 oldest .. 2 newest].
    typedef sobel_et_pkg::pixel_t window_t [3][3];

    // ------------------------------------------------------------------
    // Configuration registers. The image sizes are stored already clamped
    // to the range from three to MAX_WIDTH or MAX_HEIGHT.
    // ------------------------------------------------------------------
    sobel_et_pkg::thr_t thr_reg,    thr_next;
    width_t             width_reg,  width_next;
    height_t            height_reg, height_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next    = thr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sobel_et_pkg::CFG_EDGE_THRESHOLD:
                begin
                    thr_next = cfg_data[sobel_et_pkg::THR_W-1:0];
                end
                sobel_et_pkg::CFG_IMAGE_WIDTH:
                begin
                    if (int'(cfg_data) < sobel_et_pkg::MIN_SIZE)
                        width_next = width_t'(sobel_et_pkg::MIN_SIZE);
                    else if (int'(cfg_data) > MAX_WIDTH)
                        width_next = width_t'(MAX_WIDTH);
                    else
                        width_next = width_t'(cfg_data);
                end
                sobel_et_pkg::CFG_IMAGE_HEIGHT:
                begin
                    if (int'(cfg_data) < sobel_et_pkg::MIN_SIZE)
                        height_next = height_t'(sobel_et_pkg::MIN_SIZE);
                    else if (int'(cfg_data) > MAX_HEIGHT)
                        height_next = height_t'(MAX_HEIGHT);
                    else
                        height_next = height_t'(cfg_data);
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= sobel_et_pkg::thr_t'(sobel_et_pkg::THR_RESET);
            width_reg  <= width_t'(WIDTH_RESET_C);
            height_reg <= height_t'(HEIGHT_RESET_C);
        end
        else
        begin
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage 1 holds the accepted pixel and the line
    // store read data, stage 2 is the window with the pending centre, and
    // stage 3 is the result register.
    // ------------------------------------------------------------------
    logic s1_valid_reg,  s1_valid_next;
    logic s2_valid_reg,  s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, s2_move, s2_free, s1_move, s1_free, pixel_accept;

    assign out_free     = !out_valid_reg || !result_stall;
    assign s2_move      = s2_valid_reg && out_free;
    assign s2_free      = !s2_valid_reg || out_free;
    assign s1_move      = s1_valid_reg && s2_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign pixel_stall  = !s1_free;
    assign pixel_accept = pixel_valid && s1_free;

    // ------------------------------------------------------------------
    // Column and row counters. A count at or beyond the size wraps first,
    // then the position after this pixel is stored, wrapped again.
    // ------------------------------------------------------------------
    col_t    col_count_reg, col_count_next;
    row_t    row_count_reg, row_count_next;
    col_t    col_pre;
    row_t    row_pre;
    height_t row_step;
    width_t  col_inc;
    height_t row_inc;

    always_comb
    begin
        if ({1'b0, col_count_reg} >= width_reg)
        begin
            col_pre  = '0;
            row_step = {1'b0, row_count_reg} + height_t'(1);
        end
        else
        begin
            col_pre  = col_count_reg;
            row_step = {1'b0, row_count_reg};
        end
        row_pre = (row_step >= height_reg) ? '0 : row_step[RW-1:0];

        col_inc        = {1'b0, col_pre} + width_t'(1);
        row_inc        = {1'b0, row_pre} + height_t'(1);
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (pixel_accept)
        begin
            if (col_inc >= width_reg)
            begin
                col_count_next = '0;
                row_count_next = (row_inc >= height_reg) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_count_next = col_inc[AW-1:0];
                row_count_next = row_pre;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accepted pixel, its position and the two line store reads.
    // ------------------------------------------------------------------
    sobel_et_pkg::pixel_t pix_s1_reg;
    col_t                 col_s1_reg;
    row_t                 row_s1_reg;
    sobel_et_pkg::pixel_t upper_rd_reg;
    sobel_et_pkg::pixel_t middle_rd_reg;

    sobel_et_pkg::pixel_t upper_mem  [MAX_WIDTH];
    sobel_et_pkg::pixel_t middle_mem [MAX_WIDTH];

    // The write of one pixel and the read of the next never share an
    // address, since a row holds at least three pixels.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            upper_rd_reg  <= upper_mem[col_pre];
            middle_rd_reg <= middle_mem[col_pre];
        end
        if (s1_move)
        begin
            upper_mem[col_s1_reg]  <= middle_rd_reg;
            middle_mem[col_s1_reg] <= pix_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            pix_s1_reg <= gray_pixel;
            col_s1_reg <= col_pre;
            row_s1_reg <= row_pre;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the window. Every pixel shifts it; only a pixel that
    // completes a window leaves a centre pending for stage 3.
    // ------------------------------------------------------------------
    window_t              win_reg, win_next;
    sobel_et_pkg::coord_t ccol_s2_reg, crow_s2_reg;
    logic                 emit_s1;

    assign emit_s1 = (col_s1_reg >= col_t'(2)) && (row_s1_reg >= row_t'(2));

    always_comb
    begin
        win_next = win_reg;
        if (s1_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = upper_rd_reg;
            win_next[1][2] = middle_rd_reg;
            win_next[2][2] = pix_s1_reg;
        end
    end

    always_comb
    begin
        if (s1_move)
            s2_valid_next = emit_s1;
        else if (s2_move)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;

        s1_valid_next = pixel_accept || (s1_valid_reg && !s1_move);
        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            ccol_s2_reg <= sobel_et_pkg::coord_t'(col_s1_reg - col_t'(1));
            crow_s2_reg <= sobel_et_pkg::coord_t'(row_s1_reg - row_t'(1));
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gradients and threshold into the result register. Each
    // gradient is the difference of two weighted sums of at most 1020, so
    // its absolute value is taken as the larger sum minus the smaller.
    // ------------------------------------------------------------------
    half_t                gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
    sobel_et_pkg::mag_t   mag;
    sobel_et_pkg::coord_t ccol_reg, crow_reg;
    sobel_et_pkg::mag_t   mag_reg;
    logic                 edge_reg;

    always_comb
    begin
        gx_pos = half_t'(win_reg[0][2]) + half_t'({win_reg[1][2], 1'b0})
               + half_t'(win_reg[2][2]);
        gx_neg = half_t'(win_reg[0][0]) + half_t'({win_reg[1][0], 1'b0})
               + half_t'(win_reg[2][0]);
        gy_pos = half_t'(win_reg[2][0]) + half_t'({win_reg[2][1], 1'b0})
               + half_t'(win_reg[2][2]);
        gy_neg = half_t'(win_reg[0][0]) + half_t'({win_reg[0][1], 1'b0})
               + half_t'(win_reg[0][2]);
        gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        mag    = sobel_et_pkg::mag_t'(gx_abs) + sobel_et_pkg::mag_t'(gy_abs);
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            ccol_reg <= ccol_s2_reg;
            crow_reg <= crow_s2_reg;
            mag_reg  <= mag;
            edge_reg <= (mag > thr_reg);
        end
    end

    assign result_valid   = out_valid_reg;
    assign center_col     = ccol_reg;
    assign center_row     = crow_reg;
    assign grad_magnitude = mag_reg;
    assign is_edge        = edge_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> s1_valid_reg)
        else $error("accepted pixel did not reach stage 1");

    a_no_border_result : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (center_col != '0) && (center_row != '0))
        else $error("result delivered for a border pixel");

    a_mag_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(grad_magnitude) <= sobel_et_pkg::MAG_MAX))
        else $error("gradient magnitude out of range");

    a_result_from_window : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s2_valid_reg))
        else $error("result appeared without a pending window centre");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold testbench
// Streams grayscale frames of changing size into the edge detector, predicts
// every centre-pixel result with a scoreboard that mirrors the 3x3 window and
// both line stores, and compares the results field by field in order. Both
// channels idle and stall at random, and the receiver once holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_LINE      = sobel_et_pkg::MAX_WIDTH_DEFAULT;
    localparam int          MAX_ROWS      = sobel_et_pkg::MAX_HEIGHT_DEFAULT;
    localparam int          THR_MAX       = 2047;
    localparam int          SIZE_MAX      = 4095;
    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int          RANDOM_PIXELS = 320;
    localparam int          REPORT_LIMIT  = 10;

    // One centre-pixel result as it leaves the block.
    typedef struct packed {
        sobel_et_pkg::coord_t col;
        sobel_et_pkg::coord_t row;
        sobel_et_pkg::mag_t   mag;
        logic                 is_edge;
    } centre_result_t;

    // A 3x5 frame whose three centre pixels give the largest possible
    // magnitude (a diagonal step), a weaker corner, and a pure horizontal
    // edge.
    localparam sobel_et_pkg::pixel_t DIRECTED_FRAME [15] = '{
        8'd0,   8'd0,   8'd255,
        8'd0,   8'd255, 8'd255,
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255,
        8'd0,   8'd0,   8'd0
    };

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the window, the two line stores, the
    // position counters and the registers, and queues the centre results
    // that each accepted pixel is due to produce.
    // ------------------------------------------------------------------------
    class gradient_scoreboard;
        sobel_et_pkg::pixel_t    upper_line [MAX_LINE];
        sobel_et_pkg::pixel_t    middle_line [MAX_LINE];
        sobel_et_pkg::pixel_t    window [3][3];
        int unsigned             col_count;
        int unsigned             row_count;
        sobel_et_pkg::thr_t      threshold;
        sobel_et_pkg::cfg_data_t width_setting;
        sobel_et_pkg::cfg_data_t height_setting;
        centre_result_t          results_due [$];
        int unsigned             failures;

        function new();
            int k;
            for (k = 0; k < MAX_LINE; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            window         = '{default: '0};
            col_count      = 0;
            row_count      = 0;
            threshold      = sobel_et_pkg::thr_t'(sobel_et_pkg::THR_RESET);
            width_setting  = sobel_et_pkg::cfg_data_t'(sobel_et_pkg::WIDTH_RESET);
            height_setting = sobel_et_pkg::cfg_data_t'(sobel_et_pkg::HEIGHT_RESET);
            failures       = 0;
        endfunction

        static function int unsigned clamp_size(int unsigned value, int unsigned hi);
            if (value < sobel_et_pkg::MIN_SIZE)
                return sobel_et_pkg::MIN_SIZE;
            if (value > hi)
                return hi;
            return value;
        endfunction

        function int unsigned current_width();
            return clamp_size(width_setting, MAX_LINE);
        endfunction

        function bit at_frame_start();
            return col_count == 0 && row_count == 0;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        function void note_register(sobel_et_pkg::cfg_index_t index,
                                    sobel_et_pkg::cfg_data_t value);
            case (index)
                sobel_et_pkg::CFG_EDGE_THRESHOLD: threshold = sobel_et_pkg::thr_t'(value);
                sobel_et_pkg::CFG_IMAGE_WIDTH:    width_setting  = value;
                sobel_et_pkg::CFG_IMAGE_HEIGHT:   height_setting = value;
                default: ;
            endcase
        endfunction

        function void note_pixel(sobel_et_pkg::pixel_t pix);
            int unsigned    w;
            int unsigned    h;
            int unsigned    c;
            int unsigned    r;
            int             gx;
            int             gy;
            int             mag;
            int             k;
            centre_result_t due;
            w = current_width();
            h = clamp_size(height_setting, MAX_ROWS);
            // A shrunk size leaves the counters past the limit; they wrap here.
            if (col_count >= w) begin
                col_count = 0;
                row_count++;
            end
            if (row_count >= h)
                row_count = 0;
            c = col_count;
            r = row_count;

            for (k = 0; k < 3; k++) begin
                window[k][0] = window[k][1];
                window[k][1] = window[k][2];
            end
            window[0][2]   = upper_line[c];
            window[1][2]   = middle_line[c];
            window[2][2]   = pix;
            upper_line[c]  = middle_line[c];
            middle_line[c] = pix;

            if (c >= 2 && r >= 2) begin
                gx = int'(window[0][2]) + 2 * int'(window[1][2]) + int'(window[2][2])
                   - int'(window[0][0]) - 2 * int'(window[1][0]) - int'(window[2][0]);
                gy = int'(window[2][0]) + 2 * int'(window[2][1]) + int'(window[2][2])
                   - int'(window[0][0]) - 2 * int'(window[0][1]) - int'(window[0][2]);
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                due.col     = sobel_et_pkg::coord_t'(c - 1);
                due.row     = sobel_et_pkg::coord_t'(r - 1);
                due.mag     = sobel_et_pkg::mag_t'(mag);
                due.is_edge = (mag > int'(threshold));
                results_due = {results_due, due};
            end

            col_count = c + 1;
            if (col_count >= w) begin
                col_count = 0;
                row_count = r + 1;
                if (row_count >= h)
                    row_count = 0;
            end
        endfunction

        static function string describe(centre_result_t res);
            return $sformatf("col=%0d row=%0d mag=%0d edge=%0d",
                             res.col, res.row, res.mag, res.is_edge);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void check_result(centre_result_t got);
            centre_result_t want;
            if (results_due.size() == 0) begin
                note_failure({"unexpected result: ", describe(got)});
                return;
            end
            want = results_due.pop_front();
            if (got.col !== want.col || got.row !== want.row ||
                got.mag !== want.mag || got.is_edge !== want.is_edge)
                note_failure({"expected ", describe(want), ", got ", describe(got)});
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals.
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     pixel_valid;
    logic                     pixel_stall;
    sobel_et_pkg::pixel_t     gray_pixel;
    logic                     result_valid;
    logic                     result_stall;
    sobel_et_pkg::coord_t     center_col;
    sobel_et_pkg::coord_t     center_row;
    sobel_et_pkg::mag_t       grad_magnitude;
    logic                     is_edge;
    logic                     cfg_valid;
    logic                     cfg_ready;
    sobel_et_pkg::cfg_index_t cfg_index;
    sobel_et_pkg::cfg_data_t  cfg_data;

    gradient_scoreboard   board;
    int                   hold_request = 0;
    sobel_et_pkg::pixel_t last_pixel = '0;
    int unsigned          cycle_count = 0;

    sobel_edge_threshold DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .gray_pixel     (gray_pixel),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .center_col     (center_col),
        .center_row     (center_row),
        .grad_magnitude (grad_magnitude),
        .is_edge        (is_edge),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // The run is cut short if it outlives any plausible correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sobel_edge_threshold regression: fail");
            $finish;
        end
    end

    // Length of an idle stretch. Mode 0 never idles, mode 1 idles now and then,
    // mode 2 idles often. Most stretches are short, a few are long.
    function automatic int idle_gap(int mode);
        int roll;
        if (mode == 0)
            return 0;
        roll = $urandom_range(99);
        if (roll < (mode == 1 ? 80 : 40))
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pixel content: a mix of fully random values, the two extremes, and
    // small steps from the previous pixel so that smooth areas appear too.
    function automatic sobel_et_pkg::pixel_t next_pixel();
        int roll;
        int value;
        roll = $urandom_range(99);
        if (roll < 45)
            value = $urandom_range(0, 255);
        else if (roll < 70)
            value = $urandom_range(1) ? 255 : 0;
        else begin
            value = int'(last_pixel) + int'($urandom_range(0, 32)) - 16;
            if (value < 0)
                value = 0;
            if (value > 255)
                value = 255;
        end
        last_pixel = sobel_et_pkg::pixel_t'(value);
        return last_pixel;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Each is entered just after a rising edge and leaves just
    // after one, so every input changes only at the clock edge.
    // ------------------------------------------------------------------------

    // Writes all three registers back to back, keeping cfg_valid high.
    task automatic write_settings(sobel_et_pkg::cfg_data_t thr,
                                  sobel_et_pkg::cfg_data_t width,
                                  sobel_et_pkg::cfg_data_t height);
        sobel_et_pkg::cfg_index_t reg_index [3];
        sobel_et_pkg::cfg_data_t  reg_value [3];
        int                       k;
        reg_index = '{sobel_et_pkg::CFG_EDGE_THRESHOLD, sobel_et_pkg::CFG_IMAGE_WIDTH,
                      sobel_et_pkg::CFG_IMAGE_HEIGHT};
        reg_value = '{thr, width, height};
        for (k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data  <= reg_value[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.note_register(reg_index[k], reg_value[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one pixel after an optional gap and waits for its transfer.
    // pixel_valid is left high so that the next pixel may follow at once.
    task automatic send_pixel(sobel_et_pkg::pixel_t value, int gap);
        if (gap > 0) begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        gray_pixel  <= value;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        board.note_pixel(value);
    endtask

    task automatic send_random_pixels(int count, int mode);
        int k;
        for (k = 0; k < count; k++)
            send_pixel(next_pixel(), idle_gap(mode));
        pixel_valid <= 1'b0;
    endtask

    // Settings change only with nothing in flight: every due result has been
    // transferred, and a pixel that produces no result may still be inside,
    // so a settling wait follows.
    task automatic wait_idle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The image may only grow at the start of a frame: growing it mid-frame
    // would read line store entries that were never written.
    task automatic finish_frame(int mode);
        if (!board.at_frame_start()) begin
            while (!board.at_frame_start())
                send_pixel(next_pixel(), idle_gap(mode));
            pixel_valid <= 1'b0;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks every transfer and decides the stall for the next
    // cycle. The idling style changes at random, and a hold-off request from
    // the stimulus stalls for as long as it asks.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int             stall_left;
        int             mode;
        int             mode_left;
        centre_result_t got;
        stall_left = 0;
        mode       = 0;
        mode_left  = 0;
        result_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_valid && !result_stall) begin
                got.col     = center_col;
                got.row     = center_row;
                got.mag     = grad_magnitude;
                got.is_edge = is_edge;
                board.check_result(got);
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (stall_left == 0)
                stall_left = idle_gap(mode);
            if (stall_left > 0) begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed frame, a backed-up phase, then random phases of
    // random size and threshold, one of them at the largest width.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                      sent;
        int                      phase;
        int                      count;
        int                      mode;
        int                      k;
        sobel_et_pkg::cfg_data_t thr;
        sobel_et_pkg::cfg_data_t width;
        sobel_et_pkg::cfg_data_t height;

        board = new();
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        gray_pixel  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= sobel_et_pkg::CFG_EDGE_THRESHOLD;
        cfg_data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame at the smallest width, reset threshold kept: the
        // diagonal step gives the largest magnitude, the next centre a weaker
        // corner and the last one a pure horizontal edge. Every row start
        // refills the window with no result from the stale columns.
        write_settings(sobel_et_pkg::cfg_data_t'(sobel_et_pkg::THR_RESET),
                       sobel_et_pkg::cfg_data_t'(sobel_et_pkg::MIN_SIZE),
                       sobel_et_pkg::cfg_data_t'(5));
        for (k = 0; k < 15; k++)
            send_pixel(DIRECTED_FRAME[k], 0);
        pixel_valid <= 1'b0;
        wait_idle();

        // Sizes below the minimum are used as the minimum. Threshold zero
        // flags every non-flat pixel. The receiver holds off for a long
        // stretch while pixels keep coming, so the block fills and stalls.
        write_settings('0, '0, sobel_et_pkg::cfg_data_t'(1));
        hold_request = 150;
        send_random_pixels(60, 0);
        wait_idle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            phase++;
            mode = $urandom_range(2);
            if (phase == 4) begin
                // Width above the maximum is clamped to it; the start of the
                // first row of such a frame is streamed.
                finish_frame(mode);
                count = $urandom_range(20, 70);
                write_settings(sobel_et_pkg::cfg_data_t'($urandom_range(0, SIZE_MAX)),
                               sobel_et_pkg::cfg_data_t'(SIZE_MAX), '0);
                send_random_pixels(count, mode);
                wait_idle();
                sent += count;
            end
            else begin
                case ($urandom_range(3))
                    0:       thr = '0;
                    1:       thr = sobel_et_pkg::cfg_data_t'(THR_MAX);
                    2:       thr = sobel_et_pkg::cfg_data_t'($urandom_range(0, SIZE_MAX));
                    default: thr = sobel_et_pkg::cfg_data_t'($urandom_range(0, 1600));
                endcase
                if (phase == 1)
                    thr = sobel_et_pkg::cfg_data_t'(THR_MAX);

                // Growth only at a frame start; otherwise the width shrinks or
                // stays, which may leave the column counter past the new end.
                if (board.at_frame_start() && $urandom_range(3) != 0)
                    width = ($urandom_range(7) == 0) ?
                            sobel_et_pkg::cfg_data_t'($urandom_range(0, 2)) :
                            sobel_et_pkg::cfg_data_t'($urandom_range(3, 24));
                else
                    width = sobel_et_pkg::cfg_data_t'($urandom_range(0,
                                board.current_width() < 24 ? board.current_width() : 24));

                // One phase runs with the tallest frame; the next one then
                // shrinks the height, which may leave the row counter past the new end.
                if (phase == 2)
                    height = sobel_et_pkg::cfg_data_t'(SIZE_MAX);
                else
                    height = ($urandom_range(7) == 0) ?
                             sobel_et_pkg::cfg_data_t'($urandom_range(0, 2)) :
                             sobel_et_pkg::cfg_data_t'($urandom_range(3, 12));

                count = $urandom_range(20, 70);
                write_settings(thr, width, height);
                send_random_pixels(count, mode);
                wait_idle();
                sent += count;
            end
        end

        wait_idle();
        if (board.failures == 0)
            $display("sobel_edge_threshold regression: pass");
        else
            $display("sobel_edge_threshold regression: fail");
        $finish;
    end

endmodule
